[sv/gdf_pkg.sv]
`timescale 1ns / 1ps
package gdf_pkg;

  localparam int CW    = 32;
  localparam int SW    = 24;
  localparam int EW    = 24;
  localparam int DIFW  = CW + 1;
  localparam int SUMW  = ((EW > SW) ? EW : SW) + 1;
  localparam int DW    = (DIFW > SUMW) ? DIFW : SUMW;
  localparam int QW    = DIFW;
  localparam int NW    = QW + DW;
  localparam int LATENCY = 2 * QW + 7;

  localparam logic [EW-1:0] EResetVal = EW'(1000);

  typedef struct packed {
    logic                 eq;
    logic                 nd;
    logic                 neg;
    logic signed [CW-1:0] gd;
    logic signed [CW-1:0] dd;
    logic signed [CW-1:0] go;
    logic signed [CW-1:0] dk;
    logic [DIFW-1:0]      dif_dom;
    logic [EW-1:0]        e;
    logic [SW-1:0]        s;
  } item_t;

  typedef struct packed {
    logic                 eq;
    logic                 nd;
    logic                 neg;
    logic                 zs;
    logic signed [CW-1:0] gd;
    logic signed [CW-1:0] dd;
    logic signed [CW-1:0] mn;
    logic [DIFW-1:0]      b;
    logic [DIFW-1:0]      dob;
    logic signed [CW-1:0] est_dom;
  } tag_t;

  function automatic logic [DIFW-1:0] abs_diff(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
    logic signed [DIFW-1:0] t;
    t = DIFW'(a) - DIFW'(b);
    return t[DIFW-1] ? DIFW'(-t) : DIFW'(t);
  endfunction

endpackage

[sv/gdf_front.sv]
`timescale 1ns / 1ps
module gdf_front import gdf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [EW-1:0]        cfg_data_i,
  input  logic signed [CW-1:0] gps_east_i,
  input  logic signed [CW-1:0] gps_north_i,
  input  logic [SW-1:0]        gps_sigma_i,
  input  logic signed [CW-1:0] dr_east_i,
  input  logic signed [CW-1:0] dr_north_i,
  output item_t                item_o
);

  logic [EW-1:0] e_q;
  logic [DIFW-1:0] dge, dgn;
  logic nd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q <= EResetVal;
    end else if (cfg_valid_i) begin
      e_q <= cfg_data_i;
    end
  end

  // North wins the tie, which also covers the equal-position case.
  always_comb begin
    dge = abs_diff(gps_east_i, dr_east_i);
    dgn = abs_diff(gps_north_i, dr_north_i);
    nd  = !(dge > dgn);
    item_o.eq      = (gps_east_i == dr_east_i) && (gps_north_i == dr_north_i);
    item_o.nd      = nd;
    item_o.gd      = nd ? gps_north_i : gps_east_i;
    item_o.dd      = nd ? dr_north_i : dr_east_i;
    item_o.go      = nd ? gps_east_i : gps_north_i;
    item_o.dk      = nd ? dr_east_i : dr_north_i;
    item_o.neg     = nd ? (gps_north_i < dr_north_i) : (gps_east_i < dr_east_i);
    item_o.dif_dom = nd ? dgn : dge;
    item_o.e       = e_q;
    item_o.s       = gps_sigma_i;
  end

endmodule

[sv/gdf_queue.sv]
`timescale 1ns / 1ps
module gdf_queue import gdf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  pop_o,
  output item_t item_o
);

  item_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  // The back end never stalls, so every stored word leaves on the next edge.
  assign pop_o  = (cnt_q != 2'd0);
  assign full_o = (cnt_q == 2'd2);
  assign item_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_o ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

[sv/gdf_div.sv]
`timescale 1ns / 1ps
module gdf_div import gdf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  input  tag_t          tag_i,
  output logic          valid_o,
  output logic [QW-1:0] q_o,
  output logic          rem_nz_o,
  output tag_t          tag_o
);

  logic [DW-1:0] r_q [QW+1];
  logic [DW-1:0] r_d [QW+1];
  logic [QW-1:0] n_q [QW+1];
  logic [QW-1:0] n_d [QW+1];
  logic [QW-1:0] q_q [QW+1];
  logic [QW-1:0] q_d [QW+1];
  logic [DW-1:0] d_q [QW+1];
  tag_t          tag_q [QW+1];
  logic          v_q [QW+1];
  logic [DW:0]   t;
  logic          ge;

  // The quotient is known to fit QW bits, so the top dividend bits start
  // out as a partial remainder below the divisor.
  always_comb begin
    r_d[0] = n_i[NW-1:QW];
    n_d[0] = n_i[QW-1:0];
    q_d[0] = '0;
    t      = '0;
    ge     = 1'b0;
    for (int s = 1; s <= QW; s++) begin
      t      = {r_q[s-1], n_q[s-1][QW-1]};
      ge     = (t >= {1'b0, d_q[s-1]});
      r_d[s] = ge ? DW'(t - {1'b0, d_q[s-1]}) : t[DW-1:0];
      n_d[s] = {n_q[s-1][QW-2:0], 1'b0};
      q_d[s] = {q_q[s-1][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QW; s++) v_q[s] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int s = 1; s <= QW; s++) v_q[s] <= v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s <= QW; s++) begin
      r_q[s] <= r_d[s];
      n_q[s] <= n_d[s];
      q_q[s] <= q_d[s];
    end
    d_q[0]   <= d_i;
    tag_q[0] <= tag_i;
    for (int s = 1; s <= QW; s++) begin
      d_q[s]   <= d_q[s-1];
      tag_q[s] <= tag_q[s-1];
    end
  end

  assign valid_o  = v_q[QW];
  assign q_o      = q_q[QW];
  assign rem_nz_o = (r_q[QW] != '0);
  assign tag_o    = tag_q[QW];

endmodule

[sv/gdf_back.sv]
`timescale 1ns / 1ps
module gdf_back import gdf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  item_t                item_i,
  output logic                 done_o,
  output logic signed [CW-1:0] est_east_o,
  output logic signed [CW-1:0] est_north_o,
  output logic                 north_dominant_o
);

  logic          m1_v_q;
  logic [NW-1:0] m1_p_q;
  logic [DW-1:0] m1_d_q;
  tag_t          m1_tag_q, m1_tag_d;
  logic [SUMW-1:0] sum;

  logic          v1;
  logic [QW-1:0] q1;
  logic          r1nz;
  tag_t          t1;

  logic signed [DIFW:0] ddx, q1x, edom;
  logic signed [CW-1:0] est_dom;

  logic            a_v_q;
  tag_t            a_tag_q, a_tag_d;
  logic [DIFW-1:0] a_q;

  logic          m2_v_q;
  logic [NW-1:0] m2_p_q;
  logic [DW-1:0] m2_d_q;
  tag_t          m2_tag_q;

  logic          v2;
  logic [QW-1:0] q2;
  logic          r2nz;
  tag_t          t2;

  logic signed [DIFW:0] mnx, q2x, eoth;
  logic signed [CW-1:0] est_oth;

  always_comb begin
    sum = SUMW'(item_i.e) + SUMW'(item_i.s);
    m1_tag_d.eq      = item_i.eq;
    m1_tag_d.nd      = item_i.nd;
    m1_tag_d.neg     = item_i.neg;
    m1_tag_d.zs      = (sum == '0);
    m1_tag_d.gd      = item_i.gd;
    m1_tag_d.dd      = item_i.dd;
    m1_tag_d.mn      = (item_i.go < item_i.dk) ? item_i.go : item_i.dk;
    m1_tag_d.b       = item_i.dif_dom;
    m1_tag_d.dob     = abs_diff(item_i.go, item_i.dk);
    m1_tag_d.est_dom = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      a_v_q  <= 1'b0;
      m2_v_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      m1_v_q <= valid_i;
      a_v_q  <= v1;
      m2_v_q <= a_v_q;
      done_o <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_p_q   <= NW'(item_i.dif_dom) * NW'(item_i.e);
    m1_d_q   <= DW'(sum);
    m1_tag_q <= m1_tag_d;
  end

  gdf_div u_div_dom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (m1_v_q),
    .n_i      (m1_p_q),
    .d_i      (m1_d_q),
    .tag_i    (m1_tag_q),
    .valid_o  (v1),
    .q_o      (q1),
    .rem_nz_o (r1nz),
    .tag_o    (t1)
  );

  // Step from the DR value toward the GPS value, truncating toward zero.
  always_comb begin
    ddx  = (DIFW+1)'(t1.dd);
    q1x  = signed'({1'b0, q1});
    edom = t1.neg ? (ddx - q1x) : (ddx + q1x);
    if (r1nz && !t1.neg && edom < 0) begin
      edom = edom + 1;
    end else if (r1nz && t1.neg && edom > 0) begin
      edom = edom - 1;
    end
    if (t1.zs) begin
      edom = ddx;
    end
    est_dom = CW'(edom);
    a_tag_d = t1;
    a_tag_d.est_dom = est_dom;
  end

  always_ff @(posedge clk_i) begin
    a_tag_q  <= a_tag_d;
    a_q      <= abs_diff(t1.gd, est_dom);
    m2_p_q   <= NW'(a_tag_q.dob) * NW'(a_q);
    m2_d_q   <= DW'(a_tag_q.b);
    m2_tag_q <= a_tag_q;
  end

  gdf_div u_div_oth (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (m2_v_q),
    .n_i      (m2_p_q),
    .d_i      (m2_d_q),
    .tag_i    (m2_tag_q),
    .valid_o  (v2),
    .q_o      (q2),
    .rem_nz_o (r2nz),
    .tag_o    (t2)
  );

  // Equal positions divide by zero; the lower other-axis value is then DR.
  always_comb begin
    mnx  = (DIFW+1)'(t2.mn);
    q2x  = signed'({1'b0, q2});
    eoth = mnx + q2x;
    if (r2nz && eoth < 0) begin
      eoth = eoth + 1;
    end
    if (t2.eq) begin
      eoth = mnx;
    end
    est_oth = CW'(eoth);
  end

  always_ff @(posedge clk_i) begin
    est_east_o       <= t2.nd ? est_oth : t2.est_dom;
    est_north_o      <= t2.nd ? t2.est_dom : est_oth;
    north_dominant_o <= t2.nd;
  end

endmodule

[sv/gps_dr_fuzzy_position_fusion.sv]
`timescale 1ns / 1ps
// Fuses a GPS fix with a dead-reckoning position, one word per clock cycle
// with no gaps while busy is low. Each word taken on start passes through
// the two 33-stage restoring division pipelines in the back end before its
// result appears on done_o. A two-word queue sits between the front end and
// the back end, busy rises only if that queue fills, and results cannot be
// held off. The DR error register is sampled when an item is taken;
// cfg_ready_o is always high.
module gps_dr_fuzzy_position_fusion import gdf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] gps_east_i,
  input  logic signed [CW-1:0] gps_north_i,
  input  logic [SW-1:0]        gps_sigma_i,
  input  logic signed [CW-1:0] dr_east_i,
  input  logic signed [CW-1:0] dr_north_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [EW-1:0]        cfg_data_i,
  output logic                 done_o,
  output logic signed [CW-1:0] est_east_o,
  output logic signed [CW-1:0] est_north_o,
  output logic                 north_dominant_o
);

  item_t f_item, b_item;
  logic  push, pop;

  assign cfg_ready_o = 1'b1;
  assign push        = start && !busy;

  gdf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .gps_east_i  (gps_east_i),
    .gps_north_i (gps_north_i),
    .gps_sigma_i (gps_sigma_i),
    .dr_east_i   (dr_east_i),
    .dr_north_i  (dr_north_i),
    .item_o      (f_item)
  );

  gdf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .full_o (busy),
    .pop_o  (pop),
    .item_o (b_item)
  );

  gdf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (pop),
    .item_i           (b_item),
    .done_o           (done_o),
    .est_east_o       (est_east_o),
    .est_north_o      (est_north_o),
    .north_dominant_o (north_dominant_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ##LATENCY done_o)
    else $error("result missing after fixed latency");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(rst_ni, LATENCY) |-> $past(push, LATENCY))
    else $error("result without a matching item");

  a_never_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("queue filled although the back end never stalls");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
  import gdf_pkg::*;

  typedef struct {
    logic signed [CW-1:0] east;
    logic signed [CW-1:0] north;
    logic                 north_dom;
  } fix_t;

  localparam int CycleLimit = 400000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [CW-1:0] gps_east_i = '0;
  logic signed [CW-1:0] gps_north_i = '0;
  logic [SW-1:0]        gps_sigma_i = '0;
  logic signed [CW-1:0] dr_east_i = '0;
  logic signed [CW-1:0] dr_north_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [EW-1:0]        cfg_data_i = '0;
  logic                 done_o;
  logic signed [CW-1:0] est_east_o;
  logic signed [CW-1:0] est_north_o;
  logic                 north_dominant_o;

  logic [EW-1:0] dr_error_span = EResetVal;
  fix_t          pending_fixes[$];
  int            mismatches = 0;
  int            cycles = 0;
  bit            allow_gaps = 1'b1;

  gps_dr_fuzzy_position_fusion u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .gps_east_i       (gps_east_i),
    .gps_north_i      (gps_north_i),
    .gps_sigma_i      (gps_sigma_i),
    .dr_east_i        (dr_east_i),
    .dr_north_i       (dr_north_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .est_east_o       (est_east_o),
    .est_north_o      (est_north_o),
    .north_dominant_o (north_dominant_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[gps_dr_fuzzy_position_fusion] ERROR");
      $finish;
    end
  end

  function automatic longint span(input longint a, input longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Truncates base +/- (q + frac) toward zero, where frac is nonzero when rem is.
  function automatic longint round_in(input longint base, input bit neg,
                                      input longint q, input bit has_rem);
    longint r;
    if (!neg) begin
      r = base + q;
      if (has_rem && r < 0) r = r + 1;
    end else begin
      r = base - q;
      if (has_rem && r > 0) r = r - 1;
    end
    return r;
  endfunction

  function automatic fix_t fuse_position(input logic signed [CW-1:0] ge,
                                         input logic signed [CW-1:0] gn,
                                         input logic [SW-1:0] s,
                                         input logic signed [CW-1:0] de,
                                         input logic signed [CW-1:0] dn,
                                         input logic [EW-1:0] e);
    fix_t         f;
    bit           nd;
    longint       gd, dd, go, dk, est_dom, est_oth;
    logic [127:0] num, den, quo;
    longint       sum;
    if (ge == de && gn == dn) begin
      f.east = de;
      f.north = dn;
      f.north_dom = 1'b1;
      return f;
    end
    nd = !(span(ge, de) > span(gn, dn));
    gd = nd ? longint'(gn) : longint'(ge);
    dd = nd ? longint'(dn) : longint'(de);
    go = nd ? longint'(ge) : longint'(gn);
    dk = nd ? longint'(de) : longint'(dn);
    sum = longint'(e) + longint'(s);
    if (sum == 0) begin
      est_dom = dd;
    end else begin
      num = 128'(span(gd, dd)) * 128'(e);
      den = 128'(sum);
      quo = num / den;
      est_dom = round_in(dd, gd < dd, longint'(quo), (num % den) != 0);
    end
    num = 128'(span(go, dk)) * 128'(span(gd, est_dom));
    den = 128'(span(gd, dd));
    quo = num / den;
    est_oth = round_in((go < dk) ? go : dk, 1'b0, longint'(quo), (num % den) != 0);
    f.east = CW'(nd ? est_oth : est_dom);
    f.north = CW'(nd ? est_dom : est_oth);
    f.north_dom = nd;
    return f;
  endfunction

  always @(posedge clk_i) begin
    fix_t want;
    if (rst_ni && done_o) begin
      if (pending_fixes.size() == 0) begin
        $display("%0t: unexpected word east=%0d north=%0d nd=%0b", $time,
                 est_east_o, est_north_o, north_dominant_o);
        mismatches++;
      end else begin
        want = pending_fixes.pop_front();
        if (est_east_o !== want.east) begin
          $display("%0t: est_east expected %0d actual %0d", $time, want.east, est_east_o);
          mismatches++;
        end
        if (est_north_o !== want.north) begin
          $display("%0t: est_north expected %0d actual %0d", $time, want.north,
                   est_north_o);
          mismatches++;
        end
        if (north_dominant_o !== want.north_dom) begin
          $display("%0t: north_dominant expected %0b actual %0b", $time,
                   want.north_dom, north_dominant_o);
          mismatches++;
        end
      end
    end
  end

  // Start stays high when the next word follows directly.
  task automatic send_fix(input logic signed [CW-1:0] ge, input logic signed [CW-1:0] gn,
                          input logic [SW-1:0] s, input logic signed [CW-1:0] de,
                          input logic signed [CW-1:0] dn);
    start <= 1'b1;
    gps_east_i <= ge;
    gps_north_i <= gn;
    gps_sigma_i <= s;
    dr_east_i <= de;
    dr_north_i <= dn;
    do @(posedge clk_i); while (busy);
    pending_fixes.push_back(fuse_position(ge, gn, s, de, dn, dr_error_span));
  endtask

  task automatic maybe_gap();
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_error_span(input logic [EW-1:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dr_error_span = val;
  endtask

  function automatic logic [SW-1:0] rand_sigma();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return SW'($urandom_range(0, 5000));
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic rand_axis(output logic signed [CW-1:0] g, output logic signed [CW-1:0] d);
    g = $urandom;
    case ($urandom_range(0, 5))
      0: d = $urandom;
      1: d = g;
      2: begin
        g = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        d = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      end
      3: d = g + CW'($urandom_range(0, 200000)) - 100000;
      default: d = g + CW'($urandom_range(0, 20)) - 10;
    endcase
  endtask

  task automatic send_random(input int n);
    logic signed [CW-1:0] ge, gn, de, dn;
    repeat (n) begin
      rand_axis(ge, de);
      rand_axis(gn, dn);
      send_fix(ge, gn, rand_sigma(), de, dn);
      maybe_gap();
    end
  endtask

  task automatic test_directed();
    send_fix(100, 200, 50, 100, 200);
    send_fix(32'sh80000000, 32'sh7fffffff, '1, 32'sh80000000, 32'sh7fffffff);
    send_fix(32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff);
    send_fix(32'sh80000000, 32'sh7fffffff, '1, 32'sh7fffffff, 32'sh80000000);
    send_fix(5000, 10, 1000, 0, 0);
    send_fix(10, 5000, 1000, 0, 0);
    send_fix(-300, 300, 7, 0, 0);
    send_fix(-7, -3, 0, 5, 4);
    send_fix(1, -1, 3, 0, 0);
    maybe_gap();
    write_error_span(0);
    send_fix(1234, -987, 0, -55, 66);
    send_fix(1234, -987, 400, -55, 66);
    send_fix(-1, 1, 0, 0, 0);
    write_error_span('1);
    send_fix(32'sh7fffffff, 0, 0, 32'sh80000000, 1);
    send_fix(-999, 17, '1, 999, -17);
    send_fix(3, 2, 1, -3, -2);
    write_error_span(EResetVal);
  endtask

  task automatic test_span_settings();
    write_error_span(0);
    send_random(50);
    write_error_span('1);
    send_random(50);
    write_error_span(1);
    send_random(40);
    repeat (3) begin
      write_error_span(EW'($urandom));
      send_random(50);
    end
    write_error_span(EW'($urandom_range(0, 3000)));
    send_random(50);
  endtask

  task automatic test_drain_pause();
    send_random(10);
    drain();
    send_random(30);
  endtask

  task automatic test_back_to_back();
    allow_gaps = 1'b0;
    write_error_span(EResetVal);
    send_random(60);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_span_settings();
    test_drain_pause();
    test_back_to_back();
    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0 && pending_fixes.size() == 0) begin
      $display("[gps_dr_fuzzy_position_fusion] OK");
    end else begin
      $display("[gps_dr_fuzzy_position_fusion] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/gdf_pkg.sv
sv/gdf_front.sv
sv/gdf_queue.sv
sv/gdf_div.sv
sv/gdf_back.sv
sv/gps_dr_fuzzy_position_fusion.sv
sim/tb.sv
